[rtl/core/iss_pkg.sv]
`default_nettype none

package iss_pkg;

    localparam int CAPACITY = 32;
    localparam int KEY_BITS = 32;

    typedef logic signed [KEY_BITS-1:0] key_t;

    typedef struct packed {
        key_t key;
        logic valid;
        logic greater;
    } link_t;

endpackage

`default_nettype wire

[rtl/core/insertion_sorter.sv]
`default_nettype none

// Stable insertion sorter for signed Q16.16 keys, built as a chain of CAPACITY
// cells that each hold one key. While loading, one key enters per cycle: every
// cell compares it to its own key at once and the larger entries move up one
// place, so a beat of in_valid is taken every cycle with no gaps. Equal keys
// keep their arrival order. Keys that arrive with the chain full are dropped
// and raise overflowed for the run. A beat with is_final set is inserted, then
// the chain drains from its bottom cell, one key per cycle while out_stall is
// low, ascending, with end_of_run on the last key. in_stall stays high for the
// whole drain, and the chain is empty again once the last key has been taken.
module insertion_sorter
    import iss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  in_valid,
    output logic       in_stall,
    input  wire key_t  key,
    input  wire logic  is_final,
    output logic       out_valid,
    input  wire logic  out_stall,
    output key_t       sorted_key,
    output logic       end_of_run,
    output logic       overflowed
);

    link_t cell_link [CAPACITY];
    link_t prev_link [CAPACITY];
    link_t next_link [CAPACITY];

    logic drain_reg;
    logic drain_next;
    logic dropped_reg;
    logic dropped_next;
    logic in_accept;
    logic out_accept;
    logic full;
    logic ins_en;

    assign full       = cell_link[CAPACITY-1].valid;
    assign in_stall   = drain_reg;
    assign in_accept  = in_valid && !drain_reg;
    assign ins_en     = in_accept && !full;
    assign out_valid  = drain_reg && cell_link[0].valid;
    assign out_accept = out_valid && !out_stall;

    assign sorted_key = cell_link[0].key;
    assign end_of_run = !cell_link[1].valid;
    assign overflowed = dropped_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            if (gi == 0)
            begin : g_first
                assign prev_link[gi] = '{key: '0, valid: 1'b1, greater: 1'b0};
            end
            else
            begin : g_mid
                assign prev_link[gi] = cell_link[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_last
                assign next_link[gi] = '{key: '0, valid: 1'b0, greater: 1'b0};
            end
            else
            begin : g_inner
                assign next_link[gi] = cell_link[gi+1];
            end

            iss_cell u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .new_key   (key),
                .ins_en    (ins_en),
                .shift_en  (out_accept),
                .prev_link (prev_link[gi]),
                .next_link (next_link[gi]),
                .self_link (cell_link[gi])
            );
        end
    endgenerate

    always_comb
    begin
        drain_next   = drain_reg;
        dropped_next = dropped_reg;
        if (in_accept)
        begin
            if (full)
            begin
                dropped_next = 1'b1;
            end
            if (is_final)
            begin
                drain_next = 1'b1;
            end
        end
        if (out_accept && end_of_run)
        begin
            drain_next   = 1'b0;
            dropped_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg   <= 1'b0;
            dropped_reg <= 1'b0;
        end
        else
        begin
            drain_reg   <= drain_next;
            dropped_reg <= dropped_next;
        end
    end

endmodule

`default_nettype wire

[rtl/core/iss_cell.sv]
`default_nettype none

module iss_cell
    import iss_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire key_t  new_key,
    input  wire logic  ins_en,
    input  wire logic  shift_en,
    input  wire link_t prev_link,
    input  wire link_t next_link,
    output link_t      self_link
);

    key_t key_reg;
    key_t key_next;
    logic valid_reg;
    logic valid_next;
    logic greater;
    logic take;

    assign greater = valid_reg && ($signed(key_reg) > $signed(new_key));
    assign take    = greater || (!valid_reg && prev_link.valid);

    always_comb
    begin
        key_next   = key_reg;
        valid_next = valid_reg;
        if (shift_en)
        begin
            key_next   = next_link.key;
            valid_next = next_link.valid;
        end
        else if (ins_en && take)
        begin
            key_next   = prev_link.greater ? prev_link.key : new_key;
            valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
    end

    assign self_link.key     = key_reg;
    assign self_link.valid   = valid_reg;
    assign self_link.greater = greater;

endmodule

`default_nettype wire
